[rtl/ppit_pkg.sv]
// ============================================================================
// Point-in-polygon test package
// Shared widths, command codes, datapath command struct and saturating adder.
// ============================================================================
package ppit_pkg;

    localparam int COORD_W            = 16;
    localparam int CNT_W              = 5;
    localparam int IDX_W              = 4;
    localparam int CMD_W              = 2;
    localparam int MAX_VERTICES_DEF   = 16;
    localparam int MIN_QUERY_VERTICES = 3;
    localparam int MIN_XLATE_VERTICES = 2;

    localparam logic [CNT_W-1:0] VERTEX_COUNT_RESET = 5'd6;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_XLATE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic             capture;
        logic             ld_write;
        logic             rd_en;
        logic             rd_first;
        logic             rd_xlate;
        logic [CNT_W-1:0] rd_cnt;
        logic             hits_clear;
        logic             res_load;
        logic             res_query;
    } dp_cmd_t;

    function automatic coord_t sat_add(input coord_t a, input coord_t b);
        logic signed [COORD_W:0] s;
        coord_t                  r;
        s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
        if (s[COORD_W] != s[COORD_W-1])
        begin
            r = s[COORD_W] ? coord_t'({1'b1, {(COORD_W-1){1'b0}}})
                           : coord_t'({1'b0, {(COORD_W-1){1'b1}}});
        end
        else
        begin
            r = s[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/ppit_in_if.sv]
// ============================================================================
// Point-in-polygon command channel
// Valid/ready channel that carries one command word.
// ============================================================================
interface ppit_in_if
    import ppit_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [IDX_W-1:0] vertex_index;
    coord_t           coord_x;
    coord_t           coord_y;

    modport source (output valid, command, vertex_index, coord_x, coord_y, input ready);
    modport sink   (input valid, command, vertex_index, coord_x, coord_y, output ready);
endinterface

[rtl/ppit_out_if.sv]
// ============================================================================
// Point-in-polygon result channel
// Valid/ready channel that carries one result word.
// ============================================================================
interface ppit_out_if
    import ppit_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             inside_res;
    logic [CNT_W-1:0] crossing_count;

    modport source (output valid, inside_res, crossing_count, input ready);
    modport sink   (input valid, inside_res, crossing_count, output ready);
endinterface

[rtl/ppit_datapath.sv]
// ============================================================================
// Point-in-polygon datapath
// Vertex memory, translate write-back and the pipelined edge crossing test.
// ============================================================================
module ppit_datapath
    import ppit_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  dp_cmd_t          dp_cmd,
    input  logic [IDX_W-1:0] vertex_index,
    input  coord_t           coord_x,
    input  coord_t           coord_y,
    output logic             dp_busy,
    output logic             inside_res,
    output logic [CNT_W-1:0] crossing_count
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int PW = 2 * (COORD_W + 1);

    coord_t vx_mem [MAX_VERTICES];
    coord_t vy_mem [MAX_VERTICES];

    logic [IDX_W-1:0] idx_reg;
    coord_t           px_reg;
    coord_t           py_reg;

    coord_t           rd_x_reg;
    coord_t           rd_y_reg;
    logic [AW-1:0]    rd_addr_reg;
    logic             rd_vld_reg;
    logic             rd_first_reg;
    logic             rd_xlate_reg;

    coord_t           prev_x_reg;
    coord_t           prev_y_reg;

    logic signed [PW-1:0] lhs_reg;
    logic signed [PW-1:0] rhs_reg;
    logic                 span_reg;
    logic                 dy_pos_reg;
    logic                 prod_vld_reg;

    logic [CNT_W-1:0] hits_reg;
    logic             res_inside_reg;
    logic [CNT_W-1:0] res_count_reg;

    logic [AW-1:0]    rd_addr;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    coord_t           mem_wx;
    coord_t           mem_wy;
    logic             wb_en;
    logic             idx_ok;

    logic signed [COORD_W:0] dy;
    logic signed [COORD_W:0] dx;
    logic signed [COORD_W:0] dxp;
    logic signed [COORD_W:0] dyp;
    logic signed [PW-1:0]    lhs;
    logic signed [PW-1:0]    rhs;
    logic                    spans;
    logic                    edge_vld;
    logic                    crossed;

    assign rd_addr = AW'(dp_cmd.rd_cnt);
    assign idx_ok  = (32'(idx_reg) < MAX_VERTICES);
    assign wb_en   = rd_vld_reg && rd_xlate_reg;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = AW'(idx_reg);
        mem_wx    = px_reg;
        mem_wy    = py_reg;
        if (wb_en)
        begin
            mem_we    = 1'b1;
            mem_waddr = rd_addr_reg;
            mem_wx    = sat_add(rd_x_reg, px_reg);
            mem_wy    = sat_add(rd_y_reg, py_reg);
        end
        else if (dp_cmd.ld_write && idx_ok)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            vx_mem[mem_waddr] <= mem_wx;
            vy_mem[mem_waddr] <= mem_wy;
        end
        if (dp_cmd.rd_en)
        begin
            rd_x_reg <= vx_mem[rd_addr];
            rd_y_reg <= vy_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            idx_reg <= vertex_index;
            px_reg  <= coord_x;
            py_reg  <= coord_y;
        end
        if (dp_cmd.rd_en)
        begin
            rd_addr_reg  <= rd_addr;
            rd_first_reg <= dp_cmd.rd_first;
            rd_xlate_reg <= dp_cmd.rd_xlate;
        end
        if (rd_vld_reg)
        begin
            prev_x_reg <= rd_x_reg;
            prev_y_reg <= rd_y_reg;
        end
        lhs_reg    <= lhs;
        rhs_reg    <= rhs;
        span_reg   <= edge_vld && spans;
        dy_pos_reg <= !dy[COORD_W];
        if (dp_cmd.res_load)
        begin
            res_inside_reg <= dp_cmd.res_query ? hits_reg[0] : 1'b0;
            res_count_reg  <= dp_cmd.res_query ? hits_reg : '0;
        end
    end

    // Edge stage: the previous vertex is the edge start, the fresh read its end.
    always_comb
    begin
        edge_vld = rd_vld_reg && !rd_first_reg && !rd_xlate_reg;
        spans    = ((prev_y_reg <= py_reg) && (py_reg < rd_y_reg)) ||
                   ((rd_y_reg <= py_reg) && (py_reg < prev_y_reg));
        dy  = {rd_y_reg[COORD_W-1], rd_y_reg} - {prev_y_reg[COORD_W-1], prev_y_reg};
        dx  = {rd_x_reg[COORD_W-1], rd_x_reg} - {prev_x_reg[COORD_W-1], prev_x_reg};
        dxp = {px_reg[COORD_W-1], px_reg} - {prev_x_reg[COORD_W-1], prev_x_reg};
        dyp = {py_reg[COORD_W-1], py_reg} - {prev_y_reg[COORD_W-1], prev_y_reg};
        lhs = dxp * dy;
        rhs = dyp * dx;
    end

    assign crossed = span_reg && (dy_pos_reg ? (lhs_reg < rhs_reg) : (lhs_reg > rhs_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
            hits_reg     <= '0;
        end
        else
        begin
            rd_vld_reg   <= dp_cmd.rd_en;
            prod_vld_reg <= edge_vld;
            if (dp_cmd.hits_clear)
            begin
                hits_reg <= '0;
            end
            else if (prod_vld_reg && crossed)
            begin
                hits_reg <= hits_reg + 1'b1;
            end
        end
    end

    assign dp_busy        = rd_vld_reg || prod_vld_reg;
    assign inside_res     = res_inside_reg;
    assign crossing_count = res_count_reg;

endmodule

[rtl/ppit_ctrl.sv]
// ============================================================================
// Point-in-polygon controller
// Command decode, vertex walk sequencing and result handshake.
// ============================================================================
module ppit_ctrl
    import ppit_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata,
    input  logic             req_valid,
    input  logic [CMD_W-1:0] req_command,
    output logic             req_ready,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output dp_cmd_t          dp_cmd,
    input  logic             dp_busy
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [CMD_W-1:0] cmd_reg;
    logic [CMD_W-1:0] cmd_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] vcount_reg;
    logic             out_valid_reg;
    logic             out_valid_next;

    logic [CNT_W-1:0] n_act;
    logic             query_ok;
    logic             xlate_ok;
    logic             accept;
    logic             is_xlate;
    logic [CNT_W-1:0] last_cnt;

    assign n_act    = (32'(vcount_reg) < MAX_VERTICES) ? vcount_reg : CNT_W'(MAX_VERTICES);
    assign query_ok = (32'(n_act) >= MIN_QUERY_VERTICES);
    assign xlate_ok = (32'(n_act) >= MIN_XLATE_VERTICES);
    assign accept   = req_valid && req_ready;
    assign is_xlate = (cmd_reg == CMD_XLATE);
    // A query reads one vertex past the end, which wraps to vertex zero.
    assign last_cnt = is_xlate ? (n_act - 1'b1) : n_act;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        dp_cmd         = '0;
        dp_cmd.rd_xlate = is_xlate;
        dp_cmd.rd_first = (cnt_reg == '0);
        dp_cmd.rd_cnt   = (cnt_reg == n_act) ? '0 : cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    dp_cmd.capture    = 1'b1;
                    dp_cmd.hits_clear = 1'b1;
                    cmd_next          = req_command;
                    cnt_next          = '0;
                    if (req_command == CMD_LOAD)
                    begin
                        state_next = S_LOAD;
                    end
                    else if ((req_command == CMD_XLATE && xlate_ok) ||
                             (req_command == CMD_QUERY && query_ok))
                    begin
                        state_next = S_WALK;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_LOAD:
            begin
                dp_cmd.ld_write = 1'b1;
                state_next      = S_DONE;
            end
            S_WALK:
            begin
                dp_cmd.rd_en = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == last_cnt)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!dp_busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    dp_cmd.res_load  = 1'b1;
                    dp_cmd.res_query = (cmd_reg == CMD_QUERY) && query_ok;
                    out_valid_next   = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= CMD_LOAD;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            vcount_reg    <= VERTEX_COUNT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                vcount_reg <= cfg_wdata;
            end
        end
    end

`ifndef ASSERT_OFF
    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (cnt_reg <= n_act))
        else $error("vertex walk ran past the active vertex count");

    a_load_next: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req_command == CMD_LOAD) |=> (state_reg == S_LOAD))
        else $error("accepted load did not enter the load state");

    a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> !dp_busy)
        else $error("result taken while the datapath pipeline is busy");

    a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result valid raised outside the done state");
`endif

endmodule

[rtl/polygon_point_inside_test_unit.sv]
// ============================================================================
// Point-in-polygon test unit
// Vertex store with load, saturating translate and crossing-number query.
//
//   Channel    Role   Word contents
//   request    sink   command, vertex_index, coord_x, coord_y
//   response   source inside_res, crossing_count
//   cfg        write  vertex_count (cfg_we, cfg_wdata)
//
// A translate or a query walks the n active vertices; the single read
// port of the vertex memory reads one vertex a cycle. A new word is
// accepted once the previous result sits in the output register, even
// while that result waits.
// Reset clears control state only; the vertex memory holds no reset value.
// ============================================================================
module polygon_point_inside_test_unit
    import ppit_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata,
    ppit_in_if.sink          request,
    ppit_out_if.source       response
);

    dp_cmd_t dp_cmd;
    logic    dp_busy;

    ppit_ctrl #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .req_valid   (request.valid),
        .req_command (request.command),
        .req_ready   (request.ready),
        .rsp_valid   (response.valid),
        .rsp_ready   (response.ready),
        .dp_cmd      (dp_cmd),
        .dp_busy     (dp_busy)
    );

    ppit_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .dp_cmd         (dp_cmd),
        .vertex_index   (request.vertex_index),
        .coord_x        (request.coord_x),
        .coord_y        (request.coord_y),
        .dp_busy        (dp_busy),
        .inside_res     (response.inside_res),
        .crossing_count (response.crossing_count)
    );

endmodule

[tb/ppit_crossing_checker.sv]
// ============================================================================
// Point-in-polygon crossing checker
// Watches the command and result channels of the point-in-polygon unit. It
// keeps its own copy of the vertex store and the vertex count, works out the
// answer of every accepted command word and compares it, field by field, with
// the next result word. The failure count and the number of answers still
// awaited go to the testbench top.
// ============================================================================
module ppit_crossing_checker
    import ppit_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata,
    ppit_in_if               request,
    ppit_out_if              response,
    output int               failures,
    output int               pending
);

    typedef struct packed {
        logic             in_poly;
        logic [CNT_W-1:0] crossings;
    } poly_answer_t;

    coord_t           vx_store [MAX_VERTICES_DEF];
    coord_t           vy_store [MAX_VERTICES_DEF];
    logic [CNT_W-1:0] active_count;
    poly_answer_t     answer_q [$];
    poly_answer_t     got_answer;
    poly_answer_t     want_answer;
    int               result_num;

    function automatic coord_t sat_sum(input coord_t a, input coord_t b);
        int s;
        s = int'(a) + int'(b);
        if (s > 32767)
        begin
            s = 32767;
        end
        else if (s < -32768)
        begin
            s = -32768;
        end
        return coord_t'(s);
    endfunction

    function automatic poly_answer_t apply_word(input logic [CMD_W-1:0] cmd,
                                                input logic [IDX_W-1:0] idx,
                                                input coord_t x, input coord_t y);
        poly_answer_t ans;
        int           n;
        int           i;
        int           j;
        int           hits;
        longint       px;
        longint       py;
        longint       x1;
        longint       y1;
        longint       x2;
        longint       y2;
        longint       dy;
        longint       lhs;
        longint       rhs;
        ans = '0;
        n = (int'(active_count) > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : int'(active_count);
        case (cmd)
            CMD_LOAD:
            begin
                if (int'(idx) < MAX_VERTICES_DEF)
                begin
                    vx_store[idx] = x;
                    vy_store[idx] = y;
                end
            end
            CMD_XLATE:
            begin
                if (n >= MIN_XLATE_VERTICES)
                begin
                    for (i = 0; i < n; i++)
                    begin
                        vx_store[i] = sat_sum(vx_store[i], x);
                        vy_store[i] = sat_sum(vy_store[i], y);
                    end
                end
            end
            CMD_QUERY:
            begin
                if (n >= MIN_QUERY_VERTICES)
                begin
                    hits = 0;
                    px = longint'(x);
                    py = longint'(y);
                    for (i = 0; i < n; i++)
                    begin
                        j = (i + 1 == n) ? 0 : i + 1;
                        x1 = longint'(vx_store[i]);
                        y1 = longint'(vy_store[i]);
                        x2 = longint'(vx_store[j]);
                        y2 = longint'(vy_store[j]);
                        if (((y1 <= py) && (py < y2)) || ((y2 <= py) && (py < y1)))
                        begin
                            // The ray is crossed when the point lies left of the edge
                            // at its height; the sign of the y span sets the direction.
                            dy = y2 - y1;
                            lhs = (px - x1) * dy;
                            rhs = (py - y1) * (x2 - x1);
                            if ((dy > 0) ? (lhs < rhs) : (lhs > rhs))
                            begin
                                hits++;
                            end
                        end
                    end
                    ans.in_poly = hits[0];
                    ans.crossings = hits[CNT_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
        return ans;
    endfunction

    task automatic report_mismatch(input string what, input poly_answer_t want,
                                   input poly_answer_t got);
        failures++;
        if (failures <= 10)
        begin
            $display("%0t: word %0d %s: expected %0d/%0d, got %0d/%0d",
                     $time, result_num, what, want.in_poly, want.crossings,
                     got.in_poly, got.crossings);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_count = VERTEX_COUNT_RESET;
            answer_q.delete();
            failures = 0;
            result_num = 0;
            pending <= 0;
        end
        else
        begin
            if (response.valid && response.ready)
            begin
                got_answer.in_poly = response.inside_res;
                got_answer.crossings = response.crossing_count;
                if (answer_q.size() == 0)
                begin
                    report_mismatch("arrived with nothing awaited", '0, got_answer);
                end
                else
                begin
                    want_answer = answer_q.pop_front();
                    if ((got_answer.in_poly !== want_answer.in_poly) ||
                        (got_answer.crossings !== want_answer.crossings))
                    begin
                        report_mismatch("differs", want_answer, got_answer);
                    end
                end
                result_num++;
            end
            if (request.valid && request.ready)
            begin
                answer_q.push_back(apply_word(request.command, request.vertex_index,
                                              request.coord_x, request.coord_y));
            end
            if (cfg_we)
            begin
                active_count = cfg_wdata;
            end
            pending <= answer_q.size();
        end
    end

endmodule

[tb/tb.sv]
// ============================================================================
// Point-in-polygon unit testbench
// Loads polygons into the vertex store, translates them and casts query rays
// at them under several vertex counts, from zero up past the store size. A
// short directed part covers the field extremes, saturation and the zigzag
// polygon whose every edge is crossed; random polygons with queries near and
// on their vertices follow, mixed with random words. Both channel ends idle at
// random, and one long receiver hold-off fills the unit. The checker beside
// the unit predicts and compares every result word.
// ============================================================================
module tb;
    import ppit_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int NUM_PHASES     = 14;
    localparam int PHASE_WORDS    = 135;
    localparam int PRESSURE_PHASE = 4;
    localparam int LONG_HOLD      = 400;
    localparam int SETTLE_CYCLES  = 24;
    localparam int DRAIN_CYCLES   = 30;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_wdata;

    ppit_in_if  request_ch ();
    ppit_out_if response_ch ();

    int     failures;
    int     pending;
    int     cycle_count = 0;
    int     words_sent = 0;
    int     send_idle_pct = 0;
    int     stall_pct = 0;
    bit     hold_req = 1'b0;
    bit     hold_done = 1'b0;
    int     hold_left = 0;
    coord_t shadow_x [MAX_VERTICES_DEF];
    coord_t shadow_y [MAX_VERTICES_DEF];
    int     phase_counts [NUM_PHASES] = '{3, 16, 4, 31, 6, 0, 5, 12, 2, 16, 8, 1, 7, 20};

    int     ph;
    int     i;
    int     used;
    int     first_word;
    int     center_x;
    int     center_y;
    int     span;
    int     pick;
    int     sel;
    coord_t vx;
    coord_t vy;

    polygon_point_inside_test_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .request   (request_ch),
        .response  (response_ch)
    );

    ppit_crossing_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .request   (request_ch),
        .response  (response_ch),
        .failures  (failures),
        .pending   (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic coord_t clamp16(input int v);
        if (v > 32767)
        begin
            return coord_t'(32767);
        end
        if (v < -32768)
        begin
            return coord_t'(-32768);
        end
        return coord_t'(v);
    endfunction

    function automatic coord_t rand_coord();
        return coord_t'($urandom_range(16'hFFFF));
    endfunction

    function automatic coord_t offset_by(input int base, input int reach);
        return clamp16(base + int'($urandom_range(2 * reach)) - reach);
    endfunction

    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                             input coord_t x, input coord_t y);
        while ($urandom_range(99) < send_idle_pct)
        begin
            request_ch.valid <= 1'b0;
            @(posedge clk);
        end
        request_ch.valid <= 1'b1;
        request_ch.command <= cmd;
        request_ch.vertex_index <= idx;
        request_ch.coord_x <= x;
        request_ch.coord_y <= y;
        do
        begin
            @(posedge clk);
        end
        while (!request_ch.ready);
        if (cmd == CMD_LOAD)
        begin
            shadow_x[idx] = x;
            shadow_y[idx] = y;
        end
        words_sent++;
    endtask

    task automatic write_vertex_count(input int value);
        request_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value[CNT_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        response_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                response_ch.ready <= 1'b0;
                hold_left = hold_left - 1;
            end
            else
            begin
                response_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        request_ch.valid <= 1'b0;
        request_ch.command <= CMD_LOAD;
        request_ch.vertex_index <= '0;
        request_ch.coord_x <= '0;
        request_ch.coord_y <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A zigzag across y = 0 fills every slot, so each edge spans the ray.
        for (i = 0; i < MAX_VERTICES_DEF; i++)
        begin
            vx = (i == 0) ? coord_t'(-32768) :
                 (i == MAX_VERTICES_DEF - 1) ? coord_t'(32767) : coord_t'(i * 256 - 2048);
            vy = (i == 0) ? coord_t'(-32768) :
                 (i == MAX_VERTICES_DEF - 1) ? coord_t'(32767) :
                 (i % 2 == 1) ? coord_t'(1024) : coord_t'(-1024);
            send_word(CMD_LOAD, i[IDX_W-1:0], vx, vy);
        end
        send_word(CMD_QUERY, '0, coord_t'(-32768), coord_t'(0));
        send_word(CMD_QUERY, '0, coord_t'(0), coord_t'(0));
        send_word(CMD_QUERY, '1, coord_t'(32767), coord_t'(-32768));
        send_word(CMD_SPARE, '1, coord_t'(-1), coord_t'(-1));
        send_word(CMD_XLATE, '0, coord_t'(16), coord_t'(-16));
        write_vertex_count(MAX_VERTICES_DEF);
        send_word(CMD_QUERY, '0, coord_t'(-32768), coord_t'(0));
        send_word(CMD_XLATE, '0, coord_t'(32767), coord_t'(32767));
        send_word(CMD_XLATE, '1, coord_t'(-32768), coord_t'(-32768));
        send_word(CMD_QUERY, '0, coord_t'(0), coord_t'(0));
        write_vertex_count(MIN_XLATE_VERTICES);
        send_word(CMD_XLATE, '0, coord_t'(5), coord_t'(-5));
        send_word(CMD_QUERY, '0, coord_t'(0), coord_t'(0));
        write_vertex_count(1);
        send_word(CMD_XLATE, '0, coord_t'(7), coord_t'(7));
        write_vertex_count(0);
        send_word(CMD_QUERY, '0, coord_t'(-3), coord_t'(-3));
        write_vertex_count(31);
        send_word(CMD_QUERY, '0, coord_t'(-32768), coord_t'(-32768));

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_vertex_count(phase_counts[ph]);
            case (ph % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 66;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 66;
                end
                default:
                begin
                    send_idle_pct = 18;
                    stall_pct = 18;
                end
            endcase
            if (ph == PRESSURE_PHASE)
            begin
                hold_req = 1'b1;
            end
            used = (phase_counts[ph] > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : phase_counts[ph];
            first_word = words_sent;
            while (words_sent - first_word < PHASE_WORDS)
            begin
                if ($urandom_range(4) == 0)
                begin
                    repeat ($urandom_range(1, 6))
                    begin
                        send_word(CMD_W'($urandom_range(CMD_SPARE)),
                                  IDX_W'($urandom_range(MAX_VERTICES_DEF - 1)),
                                  rand_coord(), rand_coord());
                    end
                end
                else
                begin
                    span = ($urandom_range(9) == 0) ? 32767 : (1 << $urandom_range(4, 11));
                    center_x = int'($urandom_range(40000)) - 20000;
                    center_y = int'($urandom_range(40000)) - 20000;
                    for (i = 0; i < used; i++)
                    begin
                        send_word(CMD_LOAD, i[IDX_W-1:0], offset_by(center_x, span),
                                  offset_by(center_y, span));
                    end
                    repeat ($urandom_range(4, 14))
                    begin
                        sel = $urandom_range(19);
                        pick = $urandom_range(((used > 0) ? used : 1) - 1);
                        if (sel == 0)
                        begin
                            send_word(CMD_XLATE, IDX_W'($urandom_range(MAX_VERTICES_DEF - 1)),
                                      rand_coord(), rand_coord());
                        end
                        else if (sel < 3)
                        begin
                            send_word(CMD_XLATE, IDX_W'($urandom_range(MAX_VERTICES_DEF - 1)),
                                      offset_by(0, span / 4 + 1), offset_by(0, span / 4 + 1));
                        end
                        else if (sel < 7)
                        begin
                            send_word(CMD_QUERY, '0, offset_by(center_x, span),
                                      shadow_y[pick]);
                        end
                        else if (sel == 7)
                        begin
                            send_word(CMD_QUERY, '0, shadow_x[pick], shadow_y[pick]);
                        end
                        else
                        begin
                            send_word(CMD_QUERY, IDX_W'($urandom_range(MAX_VERTICES_DEF - 1)),
                                      offset_by(center_x, span + span / 4),
                                      offset_by(center_y, span + span / 4));
                        end
                    end
                end
            end
        end

        request_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[files.f]
rtl/ppit_pkg.sv
rtl/ppit_in_if.sv
rtl/ppit_out_if.sv
rtl/ppit_datapath.sv
rtl/ppit_ctrl.sv
rtl/polygon_point_inside_test_unit.sv
tb/ppit_crossing_checker.sv
tb/tb.sv
